@@ rtl/ffpba_pkg.sv @@
`default_nettype none

package ffpba_pkg;

   localparam int FUNC_W = 2;
   localparam int PAGE_FIELD_W = 11;
   localparam int BASE_W = 10;

   localparam int WORD_W = 8;
   localparam int OFF_W = 3;

   localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_FREE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CHECK = 2'd2;

   typedef enum logic [7:0] {
      ST_CLEAR   = 8'b0000_0001,
      ST_IDLE    = 8'b0000_0010,
      ST_SCAN    = 8'b0000_0100,
      ST_MARK_RD = 8'b0000_1000,
      ST_MARK_WR = 8'b0001_0000,
      ST_FREE_WR = 8'b0010_0000,
      ST_DONE    = 8'b0100_0000,
      ST_SPARE   = 8'b1000_0000
   } state_type;

endpackage

`default_nettype wire

@@ rtl/first_fit_page_bitmap_allocator_core.sv @@
// First-fit page bitmap allocator. The occupancy map (one bit per page, 1 = allocated) lives in
// a single-port synchronous RAM of 8-page words. After reset the block clears the RAM word by
// word with req_ready low. Allocate reads one map word per cycle from the word holding
// first_page until a free run of page_count pages is found or the map ends, then marks the run
// with a read and a write per word it spans. Check reads one word per cycle over its range and
// stops at the first free page. Free reads the word holding first_page and clears that page's
// bit; rejected requests go straight to the result. One request is worked at a time; a finished
// result waits in the output register while the next request is taken. Results come in request
// order, one per request.

`default_nettype none

module first_fit_page_bitmap_allocator_core #(
   parameter int MAP_PAGES = 1024
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [ffpba_pkg::FUNC_W-1:0]          req_func,
   input  wire logic [ffpba_pkg::PAGE_FIELD_W-1:0]    req_first_page,
   input  wire logic [ffpba_pkg::PAGE_FIELD_W-1:0]    req_page_count,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic                                       rsp_ok,
   output logic [ffpba_pkg::BASE_W-1:0]               rsp_base_page
);

   localparam int WORD_W = ffpba_pkg::WORD_W;
   localparam int OFF_W = ffpba_pkg::OFF_W;
   localparam int BASE_W = ffpba_pkg::BASE_W;
   localparam int IDX_W = (MAP_PAGES > 1) ? $clog2(MAP_PAGES) : 1;
   localparam int NUM_WORDS = (MAP_PAGES + WORD_W - 1) / WORD_W;
   localparam int WADDR_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int POS_A_W = (IDX_W + 1 > ffpba_pkg::PAGE_FIELD_W + 1) ?
                            IDX_W + 1 : ffpba_pkg::PAGE_FIELD_W + 1;
   localparam int POS_W = (WADDR_W + OFF_W + 1 > POS_A_W) ? WADDR_W + OFF_W + 1 : POS_A_W;
   localparam logic [WADDR_W-1:0] LastWord = WADDR_W'(NUM_WORDS - 1);
   localparam logic [POS_W-1:0] MapEndPos = POS_W'(MAP_PAGES);

   logic [WORD_W-1:0] page_mem [NUM_WORDS];
   logic [WORD_W-1:0] rdata_ff;

   ffpba_pkg::state_type state_ff, state_in;
   logic [WADDR_W-1:0]          word_ff, word_in;
   logic [ffpba_pkg::FUNC_W-1:0] op_ff, op_in;
   logic [POS_W-1:0]            count_ff, count_in;
   logic [POS_W-1:0]            run_ff, run_in;
   logic [POS_W-1:0]            base_ff, base_in;
   logic [POS_W-1:0]            end_ff, end_in;
   logic                        res_ok_ff, res_ok_in;
   logic [BASE_W-1:0]           res_base_ff, res_base_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_ok_ff, rsp_ok_in;
   logic [BASE_W-1:0]           rsp_base_ff, rsp_base_in;

   logic [WADDR_W-1:0] rd_addr;
   logic               mem_we;
   logic [WORD_W-1:0]  mem_wdata;

   logic [POS_W-1:0]   req_pos;
   logic [POS_W-1:0]   req_cnt;
   logic [WADDR_W-1:0] req_word;
   logic [WADDR_W-1:0] end_word;
   logic [POS_W-1:0]   word_pos;
   logic [POS_W-1:0]   scan_pos;
   logic [POS_W-1:0]   run_v;
   logic [POS_W-1:0]   end_v;
   logic               found_v;
   logic [WORD_W-1:0]  mask;
   logic [POS_W-1:0]   alloc_base;
   logic               bad;

   assign req_pos = POS_W'(req_first_page);
   assign req_cnt = POS_W'(req_page_count);
   assign req_word = req_pos[OFF_W +: WADDR_W];
   assign end_word = end_ff[OFF_W +: WADDR_W];
   assign word_pos = POS_W'({word_ff, OFF_W'(0)});

   always_comb begin
      run_v = run_ff;
      end_v = end_ff;
      found_v = 1'b0;
      mask = '0;
      scan_pos = word_pos;
      for (int j = 0; j < WORD_W; j++) begin
         scan_pos = word_pos + POS_W'(j);
         mask[j] = (scan_pos >= base_ff) && (scan_pos <= end_ff);
         if (!found_v && (scan_pos >= base_ff) && (scan_pos < MapEndPos)) begin
            if (!rdata_ff[j]) begin
               run_v = run_v + 1'b1;
               if (run_v == count_ff) begin
                  found_v = 1'b1;
                  end_v = scan_pos;
               end
            end else begin
               run_v = '0;
            end
         end
      end
   end

   assign alloc_base = end_v - count_ff + 1'b1;
   assign bad = |(mask & ~rdata_ff);

   always_comb begin
      state_in = state_ff;
      word_in = word_ff;
      op_in = op_ff;
      count_in = count_ff;
      run_in = run_ff;
      base_in = base_ff;
      end_in = end_ff;
      res_ok_in = res_ok_ff;
      res_base_in = res_base_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_ok_in = rsp_ok_ff;
      rsp_base_in = rsp_base_ff;
      rd_addr = word_ff;
      mem_we = 1'b0;
      mem_wdata = '0;
      case (state_ff)
         ffpba_pkg::ST_CLEAR: begin
            mem_we = 1'b1;
            if (word_ff == LastWord) begin
               state_in = ffpba_pkg::ST_IDLE;
            end else begin
               word_in = word_ff + 1'b1;
            end
         end
         ffpba_pkg::ST_IDLE: begin
            rd_addr = req_word;
            if (req_valid) begin
               word_in = req_word;
               op_in = req_func;
               count_in = req_cnt;
               run_in = '0;
               base_in = req_pos;
               end_in = req_pos;
               res_ok_in = 1'b0;
               res_base_in = '0;
               state_in = ffpba_pkg::ST_DONE;
               case (req_func)
                  ffpba_pkg::FUNC_ALLOC: begin
                     if ((req_cnt != '0) && (req_pos < MapEndPos)) begin
                        state_in = ffpba_pkg::ST_SCAN;
                     end
                  end
                  ffpba_pkg::FUNC_FREE: begin
                     if (req_pos < MapEndPos) begin
                        state_in = ffpba_pkg::ST_FREE_WR;
                     end
                  end
                  ffpba_pkg::FUNC_CHECK: begin
                     if (req_cnt == '0) begin
                        res_ok_in = 1'b1;
                     end else if (req_pos + req_cnt <= MapEndPos) begin
                        end_in = req_pos + req_cnt - 1'b1;
                        state_in = ffpba_pkg::ST_SCAN;
                     end
                  end
                  default: begin
                     state_in = ffpba_pkg::ST_DONE;
                  end
               endcase
            end
         end
         ffpba_pkg::ST_SCAN: begin
            if (op_ff == ffpba_pkg::FUNC_ALLOC) begin
               run_in = run_v;
               if (found_v) begin
                  base_in = alloc_base;
                  end_in = end_v;
                  word_in = alloc_base[OFF_W +: WADDR_W];
                  res_ok_in = 1'b1;
                  res_base_in = alloc_base[BASE_W-1:0];
                  state_in = ffpba_pkg::ST_MARK_RD;
               end else if (word_ff == LastWord) begin
                  state_in = ffpba_pkg::ST_DONE;
               end else begin
                  word_in = word_ff + 1'b1;
                  rd_addr = word_ff + 1'b1;
               end
            end else begin
               if (bad) begin
                  state_in = ffpba_pkg::ST_DONE;
               end else if (word_ff == end_word) begin
                  res_ok_in = 1'b1;
                  state_in = ffpba_pkg::ST_DONE;
               end else begin
                  word_in = word_ff + 1'b1;
                  rd_addr = word_ff + 1'b1;
               end
            end
         end
         ffpba_pkg::ST_MARK_RD: begin
            state_in = ffpba_pkg::ST_MARK_WR;
         end
         ffpba_pkg::ST_MARK_WR: begin
            mem_we = 1'b1;
            mem_wdata = rdata_ff | mask;
            if (word_ff == end_word) begin
               state_in = ffpba_pkg::ST_DONE;
            end else begin
               word_in = word_ff + 1'b1;
               state_in = ffpba_pkg::ST_MARK_RD;
            end
         end
         ffpba_pkg::ST_FREE_WR: begin
            mem_we = 1'b1;
            mem_wdata = rdata_ff & ~mask;
            res_ok_in = 1'b1;
            state_in = ffpba_pkg::ST_DONE;
         end
         ffpba_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in = res_ok_ff;
               rsp_base_in = res_base_ff;
               state_in = ffpba_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ffpba_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         page_mem[word_ff] <= mem_wdata;
      end
      rdata_ff <= page_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ffpba_pkg::ST_CLEAR;
         word_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         word_ff <= word_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      count_ff <= count_in;
      run_ff <= run_in;
      base_ff <= base_in;
      end_ff <= end_in;
      res_ok_ff <= res_ok_in;
      res_base_ff <= res_base_in;
      rsp_ok_ff <= rsp_ok_in;
      rsp_base_ff <= rsp_base_in;
   end

   assign req_ready = (state_ff == ffpba_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_ok = rsp_ok_ff;
   assign rsp_base_page = rsp_base_ff;

endmodule

`default_nettype wire

@@ rtl/ffpba_checker.sv @@
`default_nettype none

module ffpba_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_valid,
   input wire logic                               req_ready,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_ready,
   input wire logic                               rsp_ok,
   input wire logic [ffpba_pkg::BASE_W-1:0]       rsp_base_page
);

   logic [1:0] pending_ff, pending_in;
   logic       req_xfer;
   logic       rsp_xfer;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff;
      if (req_xfer && !rsp_xfer) begin
         pending_in = pending_ff + 1'b1;
      end else if (!req_xfer && rsp_xfer) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ok) && $stable(rsp_base_page))
      else $error("result changed while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> rsp_base_page == '0)
      else $error("failed result carries a base page");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("result without a request");

   assert property (@(posedge clock) disable iff (reset)
      pending_ff == 2'd2 |-> !req_ready)
      else $error("request taken with two results owed");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind first_fit_page_bitmap_allocator_core ffpba_checker u_ffpba_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_ok        (rsp_ok),
   .rsp_base_page (rsp_base_page)
);

`default_nettype wire
